/* rtl/ttss_pkg.sv */
// Shared types, constants and the glyph table for the seven-segment line encoder.
// Depends on nothing; ttss_line, the top level and the checker import it.
package ttss_pkg;

   // Number of display digits driven per line.
   localparam int unsigned DIGITS = 4;
   localparam int unsigned IDX_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam int unsigned CNT_W  = $clog2(DIGITS + 1);

   // Character codes with a special meaning.
   localparam logic [7:0] LINE_FEED = 8'h0A;
   localparam logic [7:0] DOT_CHAR  = 8'h2E;

   // Bit of the segment byte that lights the decimal point.
   localparam int unsigned DP_POS = 7;

   // Error glyphs E, r, r, !
   localparam logic [7:0] ERR_E    = 8'h79;
   localparam logic [7:0] ERR_R    = 8'h50;
   localparam logic [7:0] ERR_BANG = 8'h6B;

   typedef logic [7:0] seg_type;

   typedef struct packed {
      logic    ok;
      seg_type seg;
   } glyph_type;

   // One finished line, right-aligned, position 0 in the low byte.
   typedef struct packed {
      logic [DIGITS-1:0][7:0] segs;
      logic                   err;
   } frame_type;

   // Error glyph for a digit position; positions past the fourth are blank.
   function automatic seg_type err_glyph(input int unsigned pos);
      seg_type s;
      unique case (pos)
         0:       s = ERR_E;
         1:       s = ERR_R;
         2:       s = ERR_R;
         3:       s = ERR_BANG;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

   // Character to segment pattern; ok is low for unsupported codes.
   function automatic glyph_type glyph_of(input logic [7:0] c);
      glyph_type g;
      g.ok = 1'b1;
      unique case (c)
         8'h20: g.seg = 8'h00;
         8'h21: g.seg = 8'h6B;
         8'h2B: g.seg = 8'h46;
         8'h2D: g.seg = 8'h40;
         8'h2E: g.seg = 8'h80;
         8'h2F: g.seg = 8'h52;
         8'h3D: g.seg = 8'h48;
         8'h3F: g.seg = 8'h4B;
         8'h5B: g.seg = 8'h39;
         8'h5C: g.seg = 8'h64;
         8'h5D: g.seg = 8'h0F;
         8'h5F: g.seg = 8'h08;
         8'h30: g.seg = 8'h3F;
         8'h31: g.seg = 8'h06;
         8'h32: g.seg = 8'h5B;
         8'h33: g.seg = 8'h4F;
         8'h34: g.seg = 8'h66;
         8'h35: g.seg = 8'h6D;
         8'h36: g.seg = 8'h7D;
         8'h37: g.seg = 8'h07;
         8'h38: g.seg = 8'h7F;
         8'h39: g.seg = 8'h6F;
         8'h41: g.seg = 8'h77;
         8'h42: g.seg = 8'h7F;
         8'h43: g.seg = 8'h39;
         8'h44: g.seg = 8'h1F;
         8'h45: g.seg = 8'h79;
         8'h46: g.seg = 8'h71;
         8'h47: g.seg = 8'h3D;
         8'h48: g.seg = 8'h76;
         8'h49: g.seg = 8'h30;
         8'h4A: g.seg = 8'h1E;
         8'h4B: g.seg = 8'h75;
         8'h4C: g.seg = 8'h38;
         8'h4D: g.seg = 8'h2B;
         8'h4E: g.seg = 8'h37;
         8'h4F: g.seg = 8'h3F;
         8'h50: g.seg = 8'h73;
         8'h51: g.seg = 8'h6B;
         8'h52: g.seg = 8'h7B;
         8'h53: g.seg = 8'h6D;
         8'h54: g.seg = 8'h31;
         8'h55: g.seg = 8'h3E;
         8'h56: g.seg = 8'h2E;
         8'h57: g.seg = 8'h1D;
         8'h58: g.seg = 8'h49;
         8'h59: g.seg = 8'h6A;
         8'h5A: g.seg = 8'h5B;
         8'h61: g.seg = 8'h5F;
         8'h62: g.seg = 8'h7C;
         8'h63: g.seg = 8'h63;
         8'h64: g.seg = 8'h5E;
         8'h65: g.seg = 8'h79;
         8'h66: g.seg = 8'h71;
         8'h67: g.seg = 8'h3D;
         8'h68: g.seg = 8'h74;
         8'h69: g.seg = 8'h11;
         8'h6A: g.seg = 8'h0D;
         8'h6B: g.seg = 8'h69;
         8'h6C: g.seg = 8'h30;
         8'h6D: g.seg = 8'h55;
         8'h6E: g.seg = 8'h54;
         8'h6F: g.seg = 8'h5C;
         8'h70: g.seg = 8'h73;
         8'h71: g.seg = 8'h76;
         8'h72: g.seg = 8'h50;
         8'h73: g.seg = 8'h2D;
         8'h74: g.seg = 8'h78;
         8'h75: g.seg = 8'h1C;
         8'h76: g.seg = 8'h2A;
         8'h77: g.seg = 8'h6A;
         8'h78: g.seg = 8'h14;
         8'h79: g.seg = 8'h6E;
         8'h7A: g.seg = 8'h1B;
         default: begin
            g.ok  = 1'b0;
            g.seg = 8'h00;
         end
      endcase
      return g;
   endfunction

endpackage

/* rtl/ttss_if.sv */
// Valid/ready channel interfaces for the character input and the digit output.
// Stand-alone; no package needed.
interface ttss_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_write;

   modport source (output valid, output char_code, output end_of_write, input ready);
   modport sink   (input valid, input char_code, input end_of_write, output ready);
endinterface

interface ttss_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] digit_index;
   logic [7:0] segments;
   logic       error_shown;
   logic       last;

   modport source (output valid, output digit_index, output segments,
                   output error_shown, output last, input ready);
   modport sink   (input valid, input digit_index, input segments,
                   input error_shown, input last, output ready);
endinterface

/* rtl/ttss_line.sv */
// Character folding: keeps the digit store of the line being typed and builds the
// right-aligned frame on the last word. Depends on ttss_pkg.
module ttss_line (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          char_code,
   input  logic                end_of_write,
   output ttss_pkg::frame_type frame
);
   import ttss_pkg::*;

   logic [DIGITS-1:0][7:0] store_ff, store_in;
   logic [CNT_W-1:0]       used_ff, used_in;
   logic                   stop_ff, stop_in;
   logic                   err_ff, err_in;

   glyph_type        glyph;
   logic [IDX_W-1:0] wr_pos;
   logic [IDX_W-1:0] prev_pos;
   logic             full;
   logic [CNT_W-1:0] pad;

   assign glyph    = glyph_of(char_code);
   assign wr_pos   = IDX_W'(used_ff);
   assign prev_pos = IDX_W'(used_ff - CNT_W'(1));
   assign full     = (used_ff == CNT_W'(DIGITS));

   // Fold one character into the store, as it stands after this word.
   always_comb begin
      store_in = store_ff;
      used_in  = used_ff;
      stop_in  = stop_ff;
      err_in   = err_ff;
      if (!stop_ff) begin
         priority if (char_code == LINE_FEED) begin
            stop_in = 1'b1;
         end else if (!glyph.ok) begin
            for (int unsigned i = 0; i < DIGITS; i++) begin
               store_in[i] = err_glyph(i);
            end
            used_in = CNT_W'(DIGITS);
            stop_in = 1'b1;
            err_in  = 1'b1;
         end else if (char_code == DOT_CHAR && used_ff != '0
                      && !store_ff[prev_pos][DP_POS]) begin
            store_in[prev_pos][DP_POS] = 1'b1;
         end else if (full) begin
            for (int unsigned i = 0; i < DIGITS; i++) begin
               store_in[i] = err_glyph(i);
            end
            stop_in = 1'b1;
            err_in  = 1'b1;
         end else begin
            store_in[wr_pos] = glyph.seg;
            used_in          = used_ff + CNT_W'(1);
         end
      end
   end

   // Right-align: blank digits move in at the left (low positions).
   assign pad        = CNT_W'(DIGITS) - used_in;
   assign frame.segs = store_in << {pad, 3'b000};
   assign frame.err  = err_in;

   // Store update; the line clears itself once its frame is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
         used_ff  <= '0;
         stop_ff  <= 1'b0;
         err_ff   <= 1'b0;
      end else if (take) begin
         if (end_of_write) begin
            store_ff <= '0;
            used_ff  <= '0;
            stop_ff  <= 1'b0;
            err_ff   <= 1'b0;
         end else begin
            store_ff <= store_in;
            used_ff  <= used_in;
            stop_ff  <= stop_in;
            err_ff   <= err_in;
         end
      end
   end

endmodule

/* rtl/text_to_seven_segment_line.sv */
// Top level of the seven-segment line encoder: character folding plus a digit
// serializer. Depends on ttss_pkg, ttss_if and ttss_line.
//
//   channel  dir  word                                      accepted when
//   req      in   char_code, end_of_write                   req.valid && req.ready
//   rsp      out  digit_index, segments, error_shown, last  rsp.valid && rsp.ready
//
// One character is taken every cycle. A word with end_of_write loads the finished
// line into the frame register, which then sends DIGITS words, one per cycle unless
// stalled. While a frame is still being sent, plain characters keep flowing in;
// only the next end_of_write word waits until the frame's last digit leaves.
// Reset (synchronous) empties the digit store and drops any frame in flight.
module text_to_seven_segment_line (
   input  logic       clock,
   input  logic       reset,
   ttss_req_if.sink   req,
   ttss_rsp_if.source rsp
);
   import ttss_pkg::*;

   frame_type        frame;
   logic             req_fire;
   logic             rsp_fire;
   logic             at_last;
   logic             frame_free;

   logic [DIGITS-1:0][7:0] segs_ff;
   logic                   err_ff;
   logic                   valid_ff;
   logic [IDX_W-1:0]       idx_ff;

   assign at_last    = (idx_ff == IDX_W'(DIGITS - 1));
   assign rsp_fire   = valid_ff && rsp.ready;
   assign frame_free = !valid_ff || (rsp_fire && at_last);
   assign req.ready  = frame_free || !req.end_of_write;
   assign req_fire   = req.valid && req.ready;

   ttss_line u_line (
      .clock        (clock),
      .reset        (reset),
      .take         (req_fire),
      .char_code    (req.char_code),
      .end_of_write (req.end_of_write),
      .frame        (frame)
   );

   // Frame register: load a finished line, otherwise shift one digit out per word.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (req_fire && req.end_of_write) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (rsp_fire) begin
         if (at_last) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req.end_of_write) begin
         segs_ff <= frame.segs;
         err_ff  <= frame.err;
      end else if (rsp_fire) begin
         segs_ff <= segs_ff >> 8;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.digit_index = 2'(idx_ff);
   assign rsp.segments    = segs_ff[0];
   assign rsp.error_shown = err_ff;
   assign rsp.last        = at_last;

endmodule

/* rtl/ttss_checker.sv */
// Port-level checks on the seven-segment line encoder, bound to its top level.
// Depends on ttss_pkg and text_to_seven_segment_line.
module ttss_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_end_of_write,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_digit_index,
   input logic [7:0] rsp_segments,
   input logic       rsp_error_shown,
   input logic       rsp_last
);
   import ttss_pkg::*;

   // A stalled digit word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_segments)
         && $stable(rsp_digit_index) && $stable(rsp_last))
      else $error("digit word changed while stalled");

   // A line's digits follow one another without a gap, in order.
   a_run_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid
         && rsp_digit_index == $past(rsp_digit_index) + 2'd1)
      else $error("digit run broken or out of order");

   // The run ends on the last display position.
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_digit_index == 2'(DIGITS - 1))
      else $error("last flag on wrong digit");

   // An accepted end of line starts a fresh run at the leftmost digit.
   a_run_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_end_of_write |=> rsp_valid
         && rsp_digit_index == 2'd0)
      else $error("end of line did not start a digit run");

   // The error flag is the same over a whole run.
   a_err_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_error_shown == $past(rsp_error_shown))
      else $error("error flag changed within a run");

endmodule

bind text_to_seven_segment_line ttss_checker u_ttss_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .req_end_of_write (req.end_of_write),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_digit_index  (rsp.digit_index),
   .rsp_segments     (rsp.segments),
   .rsp_error_shown  (rsp.error_shown),
   .rsp_last         (rsp.last)
);
